// ===== design/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg - shared types and constants of the clamped PID controller
// Widths of the datapath, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 24;
    localparam int WORD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int SUM_W      = 59;   // P + I + D, exact
    localparam int DIV_W      = 76;   // divider dividend / quotient
    localparam int DEN_W      = 33;   // divider divisor magnitude
    localparam int MUL_W      = 33;   // shared multiplier operand width

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_TARGET    = 3'd3,
        REG_DRIVE_MAX = 3'd4,
        REG_DRIVE_MIN = 3'd5
    } t_reg_idx;

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_ERR   = 18'h00002,
        ST_MP    = 18'h00004,
        ST_P     = 18'h00008,
        ST_MA    = 18'h00010,
        ST_A     = 18'h00020,
        ST_MH    = 18'h00040,
        ST_ML    = 18'h00080,
        ST_I     = 18'h00100,
        ST_DDIV  = 18'h00200,
        ST_MD    = 18'h00400,
        ST_D     = 18'h00800,
        ST_SUM   = 18'h01000,
        ST_CLAMP = 18'h02000,
        ST_AWCHK = 18'h04000,
        ST_AWDIV = 18'h08000,
        ST_AWFIX = 18'h10000,
        ST_OUT   = 18'h20000
    } t_state;

endpackage

// ===== design/pid_controller_anti_windup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_anti_windup - two-step Q16.16 PID with clamp and anti-windup
// Compute items return a drive value; update items commit the state.
// ----------------------------------------------------------------------------
// One item at a time through a small sequencer around one shared 33x33 signed
// multiplier and one radix-2 restoring divider (76 steps, one bit per cycle).
// A compute item with a non-positive time step sends its unclamped P-only drive
// to the output; any other compute item also runs the integrator and the
// derivative division and returns the clamped sum. An update item runs the
// integrator and derivative steps (the division is skipped at a zero time step),
// plus a second division by gain_i when the back-calculation correction applies.
// The input is ready only while the sequencer is idle; a finished drive value
// sits in the output register and the next item may enter while it waits. A
// second drive value holds the sequencer until the first drains.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,  // measured, timestamp
    input  logic                                s_axis_tuser,  // action
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata   // drive
);
    import pidaw_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [WORD_W-1:0] r_target, r_dmax, r_dmin;

    // controller state
    logic signed [ACC_W-1:0]  r_integ;
    logic signed [WORD_W-1:0] r_last_err;
    logic        [WORD_W-1:0] r_last_time;

    // item and working registers
    t_state                   r_state, n_state;
    logic                     r_act;
    logic signed [WORD_W-1:0] r_meas;
    logic        [WORD_W-1:0] r_now;
    logic signed [WORD_W-1:0] r_err;
    logic signed [WORD_W:0]   r_dt;
    logic signed [39:0]       r_p;
    logic signed [39:0]       r_d;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [55:0]       r_ih;
    logic signed [56:0]       r_i;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [40:0]       r_pd;
    logic        [WORD_W-1:0] r_res;
    logic                     r_oval;
    logic        [WORD_W-1:0] r_drive;

    // shared multiplier
    logic signed [MUL_W-1:0]   w_ma, w_mb;
    logic signed [2*MUL_W-1:0] r_prod;

    // shared divider (magnitudes; sign applied by the consumer)
    logic [DIV_W-1:0] r_dq;
    logic [DEN_W-1:0] r_drem;
    logic [DEN_W-1:0] r_dden;
    logic [6:0]       r_dcnt;
    logic             r_dneg;
    logic [DEN_W:0]   w_rsh, w_rsub;
    logic             w_ge;

    // ---- combinational helpers ----
    logic signed [WORD_W:0]  w_ediff;
    logic signed [WORD_W-1:0] w_err;
    logic signed [ACC_W:0]   w_asum;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [WORD_W:0]  w_dnum;
    logic        [WORD_W:0]  w_dnum_mag, w_dt_mag;
    logic signed [WORD_W-1:0] w_rate;
    logic                    w_rate_big;
    logic signed [SUM_W-1:0] w_max_x, w_min_x;
    logic                    w_hi_fix, w_lo_fix;
    logic signed [SUM_W:0]   w_x;
    logic        [SUM_W:0]   w_x_mag;
    logic        [GAIN_W:0]  w_gi_mag;
    logic        [59:0]      w_qm;
    logic                    w_q_big;
    logic        [32:0]      w_qsat;
    logic        [48:0]      w_corr_mag;
    logic signed [50:0]      w_corr;
    logic signed [51:0]      w_anew;
    logic signed [ACC_W-1:0] w_acc_fix;
    logic        [WORD_W-1:0] w_ponly;
    logic        [WORD_W-1:0] w_clamped;

    always_comb begin
        // error, saturated to 32 bits
        w_ediff = {r_target[WORD_W-1], r_target} - {r_meas[WORD_W-1], r_meas};
        if (w_ediff[WORD_W] != w_ediff[WORD_W-1]) begin
            w_err = w_ediff[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            w_err = w_ediff[WORD_W-1:0];
        end

        // integrator step, saturated to 48 bits
        w_asum = {r_integ[ACC_W-1], r_integ} + {r_prod[63], r_prod[63:16]};
        if (w_asum[ACC_W] != w_asum[ACC_W-1]) begin
            w_acc = w_asum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc = w_asum[ACC_W-1:0];
        end

        // derivative division operands
        w_dnum     = {r_err[WORD_W-1], r_err} - {r_last_err[WORD_W-1], r_last_err};
        w_dnum_mag = w_dnum[WORD_W] ? (~w_dnum + 1'b1) : w_dnum;
        w_dt_mag   = r_dt[WORD_W] ? (~r_dt + 1'b1) : r_dt;

        // rate, saturated to 32 bits
        w_rate_big = |r_dq[DIV_W-1:31];
        if (r_dneg) begin
            w_rate = w_rate_big ? {1'b1, {(WORD_W-1){1'b0}}} : -$signed(r_dq[WORD_W-1:0]);
        end else begin
            w_rate = w_rate_big ? {1'b0, {(WORD_W-1){1'b1}}} : $signed(r_dq[WORD_W-1:0]);
        end

        // anti-windup decision
        w_max_x  = SUM_W'(r_dmax);
        w_min_x  = SUM_W'(r_dmin);
        w_hi_fix = (r_sum > w_max_x) && (SUM_W'(r_pd) < w_max_x);
        w_lo_fix = (r_sum < w_min_x) && (SUM_W'(r_pd) > w_min_x);
        w_x      = w_hi_fix ? ({r_sum[SUM_W-1], r_sum} - {r_dmax[WORD_W-1], (SUM_W'(r_dmax))})
                            : ({r_sum[SUM_W-1], r_sum} - {r_dmin[WORD_W-1], (SUM_W'(r_dmin))});
        w_x_mag  = w_x[SUM_W] ? (~w_x + 1'b1) : w_x;
        w_gi_mag = r_gain_i[GAIN_W-1] ? (~{1'b1, r_gain_i} + 1'b1) : {1'b0, r_gain_i};

        // correction: whole part clamped to +-2^32, fraction kept
        w_qm       = r_dq[DIV_W-1:16];
        w_q_big    = (|w_qm[59:33]) || (w_qm[32] && (|w_qm[31:0]));
        w_qsat     = w_q_big ? {1'b1, 32'd0} : w_qm[32:0];
        w_corr_mag = {w_qsat, r_dq[15:0]};
        w_corr     = r_dneg ? -$signed({2'b00, w_corr_mag}) : $signed({2'b00, w_corr_mag});
        w_anew     = {{4{r_acc[ACC_W-1]}}, r_acc} - {w_corr[50], w_corr};
        if (w_anew[51:47] != {5{w_anew[51]}}) begin
            w_acc_fix = w_anew[51] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_fix = w_anew[ACC_W-1:0];
        end

        // P-only drive, saturated; taken straight from the fresh product
        if (r_prod[55:47] != {9{r_prod[55]}}) begin
            w_ponly = r_prod[55] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            w_ponly = r_prod[47:16];
        end

        // clamp: upper limit wins when limits are inverted
        if (r_sum > w_max_x) begin
            w_clamped = r_dmax;
        end else if (r_sum < w_min_x) begin
            w_clamped = r_dmin;
        end else begin
            w_clamped = r_sum[WORD_W-1:0];
        end

        // divider step
        w_rsh  = {r_drem, r_dq[DIV_W-1]};
        w_ge   = w_rsh >= {1'b0, r_dden};
        w_rsub = w_rsh - {1'b0, r_dden};
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_MP: begin
                w_ma = MUL_W'(r_gain_p);
                w_mb = MUL_W'(r_err);
            end
            ST_MA: begin
                w_ma = MUL_W'(r_err);
                w_mb = r_dt;
            end
            ST_MH: begin
                w_ma = MUL_W'(r_gain_i);
                w_mb = MUL_W'($signed(r_acc[ACC_W-1:16]));
            end
            ST_ML: begin
                w_ma = MUL_W'(r_gain_i);
                w_mb = {17'd0, r_acc[15:0]};
            end
            ST_MD: begin
                w_ma = MUL_W'(r_gain_d);
                w_mb = MUL_W'(w_rate);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_ERR;
            ST_ERR:   n_state = ST_MP;
            ST_MP:    n_state = ST_P;
            ST_P:     n_state = (!r_act && (r_dt <= 0)) ? ST_OUT : ST_MA;
            ST_MA:    n_state = ST_A;
            ST_A:     n_state = ST_MH;
            ST_MH:    n_state = ST_ML;
            ST_ML:    n_state = ST_I;
            ST_I:     n_state = (r_dt == 0) ? ST_SUM : ST_DDIV;
            ST_DDIV:  if (r_dcnt == '0) n_state = ST_MD;
            ST_MD:    n_state = ST_D;
            ST_D:     n_state = ST_SUM;
            ST_SUM:   n_state = r_act ? ST_AWCHK : ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_AWCHK: n_state = ((w_hi_fix || w_lo_fix) && (r_gain_i != 0)) ? ST_AWDIV : ST_IDLE;
            ST_AWDIV: if (r_dcnt == '0) n_state = ST_AWFIX;
            ST_AWFIX: n_state = ST_IDLE;
            ST_OUT:   if (!r_oval || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;

        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oval      <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_target    <= '0;
            r_dmax      <= {1'b0, {(WORD_W-1){1'b1}}};
            r_dmin      <= {1'b1, {(WORD_W-1){1'b0}}};
            r_integ     <= '0;
            r_last_err  <= '0;
            r_last_time <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN_P:    r_gain_p <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:    r_gain_i <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:    r_gain_d <= i_cfg_data[GAIN_W-1:0];
                    REG_TARGET:    r_target <= i_cfg_data;
                    REG_DRIVE_MAX: r_dmax   <= i_cfg_data;
                    REG_DRIVE_MIN: r_dmin   <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register: load a new drive, else drain on ready
            if ((r_state == ST_OUT) && (!r_oval || m_axis_tready)) begin
                r_oval <= 1'b1;
            end else if (r_oval && m_axis_tready) begin
                r_oval <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act  <= s_axis_tuser;
                        r_meas <= s_axis_tdata[31:0];
                        r_now  <= s_axis_tdata[63:32];
                    end
                end
                ST_ERR: begin
                    r_err <= w_err;
                    r_dt  <= {1'b0, r_now} - {1'b0, r_last_time};
                end
                ST_P: begin
                    r_p   <= r_prod[55:16];
                    r_res <= w_ponly;
                end
                ST_A:  r_acc <= w_acc;
                ST_ML: r_ih  <= r_prod[55:0];
                ST_I: begin
                    r_i    <= {r_ih[55], r_ih} + {{32{r_prod[40]}}, r_prod[40:16]};
                    r_d    <= '0;
                    // dividend (err - last_err) * 2^16, divisor dt
                    r_dq   <= DIV_W'({w_dnum_mag, 16'd0});
                    r_drem <= '0;
                    r_dden <= w_dt_mag;
                    r_dneg <= w_dnum[WORD_W] ^ r_dt[WORD_W];
                    r_dcnt <= 7'(DIV_W - 1);
                end
                ST_DDIV, ST_AWDIV: begin
                    r_drem <= w_ge ? w_rsub[DEN_W-1:0] : w_rsh[DEN_W-1:0];
                    r_dq   <= {r_dq[DIV_W-2:0], w_ge};
                    r_dcnt <= r_dcnt - 1'b1;
                end
                ST_D: r_d <= r_prod[55:16];
                ST_SUM: begin
                    r_sum <= SUM_W'(r_p) + SUM_W'(r_i) + SUM_W'(r_d);
                    r_pd  <= 41'(r_p) + 41'(r_d);
                end
                ST_CLAMP: r_res <= w_clamped;
                ST_AWCHK: begin
                    // dividend (sum - limit) * 2^16, divisor gain_i
                    r_dq   <= DIV_W'({w_x_mag, 16'd0});
                    r_drem <= '0;
                    r_dden <= DEN_W'(w_gi_mag);
                    r_dneg <= w_x[SUM_W] ^ r_gain_i[GAIN_W-1];
                    r_dcnt <= 7'(DIV_W - 1);
                    if (!((w_hi_fix || w_lo_fix) && (r_gain_i != 0))) begin
                        r_integ     <= r_acc;
                        r_last_err  <= r_err;
                        r_last_time <= r_now;
                    end
                end
                ST_AWFIX: begin
                    r_integ     <= w_acc_fix;
                    r_last_err  <= r_err;
                    r_last_time <= r_now;
                end
                ST_OUT: begin
                    if (!r_oval || m_axis_tready) begin
                        r_drive <= r_res;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_drive;

endmodule
